>>> rtl/ofd_pkg.sv
package ofd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field and register widths fixed by the interface.
  localparam int CFG_W    = 11;
  localparam int VALUE_W  = 8;
  localparam int POS_W    = 10;
  localparam int IN_ROW_W = 11;

  // Widths that follow from the grid limits.
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIV_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int DIV_STEP_W = $clog2(CNT_W + 1);

  // The newest column of the 3x3 window comes straight from the line buffers and the
  // incoming item, so only the two older columns are held in cells.
  localparam int NUM_CELLS = 2;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_FREE     = 2'd0,
    CLS_UNKNOWN  = 2'd1,
    CLS_OCCUPIED = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t bot;
    cls_t mid;
    cls_t top;
  } col_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/ofd_if.sv
interface ofd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ofd_pkg::VALUE_W-1:0]  cell_value;
  logic                                flush;

  modport source (output valid, output cell_value, output flush, input ready);
  modport sink (input valid, input cell_value, input flush, output ready);
endinterface

interface ofd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       is_frontier;
  logic [ofd_pkg::POS_W-1:0]  cell_row;
  logic [ofd_pkg::POS_W-1:0]  cell_col;
  logic                       last_of_frame;

  modport source (output valid, output is_frontier, output cell_row, output cell_col,
                  output last_of_frame, input ready);
  modport sink (input valid, input is_frontier, input cell_row, input cell_col,
                input last_of_frame, output ready);
endinterface

interface ofd_cfg_if;
  logic                       valid;
  logic                       ready;
  ofd_pkg::cfg_reg_t          index;
  logic [ofd_pkg::CFG_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ofd_cell.sv
module ofd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ofd_pkg::cell_ctl_t ctl,
  input  ofd_pkg::col_t      col_in,
  output ofd_pkg::col_t      col_out
);

  ofd_pkg::col_t col_r;
  ofd_pkg::col_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (ctl.clear) begin
      col_nxt = '0;
    end else if (ctl.shift) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

>>> rtl/ofd_div.sv
module ofd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ofd_pkg::CNT_W-1:0]   dividend,
  input  logic [ofd_pkg::CFG_W-1:0]   divisor,
  output ofd_pkg::div_stat_t          stat,
  output logic [ofd_pkg::CNT_W-1:0]   quo,
  output logic [ofd_pkg::COL_W-1:0]   rem
);

  logic [ofd_pkg::DIV_STEP_W-1:0] cnt_r;
  logic [ofd_pkg::DIV_STEP_W-1:0] cnt_nxt;
  logic                           done_r;
  logic                           done_nxt;
  logic [ofd_pkg::CNT_W-1:0]      q_r;
  logic [ofd_pkg::CNT_W-1:0]      q_nxt;
  logic [ofd_pkg::COL_W-1:0]      rem_r;
  logic [ofd_pkg::COL_W-1:0]      rem_nxt;
  logic [ofd_pkg::COL_W:0]        cand;
  logic [ofd_pkg::DIV_W-1:0]      cand_ext;
  logic [ofd_pkg::DIV_W-1:0]      div_ext;
  logic                           ge;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    cand     = {rem_r, q_r[ofd_pkg::CNT_W-1]};
    cand_ext = ofd_pkg::DIV_W'(cand);
    div_ext  = ofd_pkg::DIV_W'(divisor);
    ge       = cand_ext >= div_ext;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = ofd_pkg::DIV_STEP_W'(ofd_pkg::CNT_W);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      q_nxt    = {q_r[ofd_pkg::CNT_W-2:0], ge};
      rem_nxt  = ge ? ofd_pkg::COL_W'(cand_ext - div_ext) : ofd_pkg::COL_W'(cand);
      done_nxt = (cnt_r == ofd_pkg::DIV_STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = (cnt_r != '0) || done_r;
  assign stat.done = done_r;
  assign quo       = q_r;
  assign rem       = rem_r;

endmodule

>>> rtl/occupancy_frontier_detect_unit.sv
// Path: a result passes the window stage register and then the output register once the item
// that completes its neighbourhood is accepted, which is grid_width+1 items after the cell itself.
// Throughput: one item per cycle, set by the line buffers and the window cells, unless the
// output stalls or a configuration write is pending: after such a write the input stalls
// while a bit-serial divider re-derives the row and column of the next reported cell.
// Reset (synchronous, active low) clears counters, window and handshakes and sets both
// dimensions to 1024; the line buffers keep their contents and are not cleared.
module occupancy_frontier_detect_unit (
  input logic         clk,
  input logic         rst_n,
  ofd_in_if.sink      in_bus,
  ofd_out_if.source   out_bus,
  ofd_cfg_if.sink     cfg_bus
);

  typedef struct packed {
    ofd_pkg::cls_t             cls;
    logic [ofd_pkg::COL_W-1:0] idx;
    logic                      emit;
    logic                      last;
    logic                      first;
    logic                      top_ok;
    logic                      bot_ok;
    logic                      left_ok;
    logic                      right_ok;
    logic [ofd_pkg::POS_W-1:0] row;
    logic [ofd_pkg::POS_W-1:0] col;
    logic                      fwd;
    ofd_pkg::cls_t             fwd_up;
    ofd_pkg::cls_t             fwd_mid;
  } p1_t;

  function automatic ofd_pkg::cls_t classify(input logic [ofd_pkg::VALUE_W-1:0] v,
                                             input logic fl);
    ofd_pkg::cls_t c;
    priority if (fl) begin
      c = ofd_pkg::CLS_OCCUPIED;
    end else if (v == '0) begin
      c = ofd_pkg::CLS_FREE;
    end else if (v == '1) begin
      c = ofd_pkg::CLS_UNKNOWN;
    end else begin
      c = ofd_pkg::CLS_OCCUPIED;
    end
    return c;
  endfunction

  function automatic logic [ofd_pkg::CFG_W-1:0] clamp_dim(input logic [ofd_pkg::CFG_W-1:0] v,
                                                         input int maxv);
    logic [ofd_pkg::CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = ofd_pkg::CFG_W'(1);
    end else if (int'(v) > maxv) begin
      r = ofd_pkg::CFG_W'(maxv);
    end
    return r;
  endfunction

  function automatic logic has_unknown(input ofd_pkg::col_t c, input logic top_ok,
                                       input logic bot_ok, input logic use_mid);
    return (top_ok && (c.top == ofd_pkg::CLS_UNKNOWN)) ||
           (use_mid && (c.mid == ofd_pkg::CLS_UNKNOWN)) ||
           (bot_ok && (c.bot == ofd_pkg::CLS_UNKNOWN));
  endfunction

  // Configuration
  logic [ofd_pkg::CFG_W-1:0] cfg_width_r;
  logic [ofd_pkg::CFG_W-1:0] cfg_width_nxt;
  logic [ofd_pkg::CFG_W-1:0] cfg_height_r;
  logic [ofd_pkg::CFG_W-1:0] cfg_height_nxt;
  logic                      cfg_pend_r;
  logic                      cfg_acc;
  logic [ofd_pkg::CFG_W-1:0] eff_w;
  logic [ofd_pkg::CFG_W-1:0] eff_h;
  logic [ofd_pkg::CNT_W:0]   total_r;

  // Position counters
  logic [ofd_pkg::COL_W-1:0]    in_col_r;
  logic [ofd_pkg::COL_W-1:0]    in_col_nxt;
  logic [ofd_pkg::IN_ROW_W-1:0] in_row_r;
  logic [ofd_pkg::IN_ROW_W-1:0] in_row_nxt;
  logic [ofd_pkg::CNT_W-1:0]    out_cnt_r;
  logic [ofd_pkg::CNT_W-1:0]    out_cnt_nxt;
  logic [ofd_pkg::CNT_W-1:0]    orow_r;
  logic [ofd_pkg::CNT_W-1:0]    orow_nxt;
  logic [ofd_pkg::COL_W-1:0]    ocol_r;
  logic [ofd_pkg::COL_W-1:0]    ocol_nxt;

  // Accept stage
  logic          in_acc;
  ofd_pkg::cls_t cls_in;
  logic          emit;
  logic          last;
  logic          col_wrap;
  logic          ocol_wrap;
  logic          bot_ok;

  // Window stage
  p1_t           p1_r;
  p1_t           p1_nxt;
  logic          p1_valid_r;
  logic          p1_valid_nxt;
  logic          p1_adv;
  ofd_pkg::cls_t rd_up_r;
  ofd_pkg::cls_t rd_mid_r;
  ofd_pkg::cls_t up_eff;
  ofd_pkg::cls_t mid_eff;
  ofd_pkg::col_t new_col;
  ofd_pkg::col_t chain [0:ofd_pkg::NUM_CELLS];
  ofd_pkg::cell_ctl_t cell_ctl;
  logic          flag;

  ofd_pkg::cls_t upper_mem  [ofd_pkg::MAX_WIDTH];
  ofd_pkg::cls_t middle_mem [ofd_pkg::MAX_WIDTH];

  // Output register
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_frontier_r;
  logic [ofd_pkg::POS_W-1:0] out_row_r;
  logic [ofd_pkg::POS_W-1:0] out_col_r;
  logic                      out_last_r;

  // Divider
  ofd_pkg::div_stat_t        div_stat;
  logic [ofd_pkg::CNT_W-1:0] div_quo;
  logic [ofd_pkg::COL_W-1:0] div_rem;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_bus.ready = 1'b1;
  assign cfg_acc       = cfg_bus.valid && cfg_bus.ready;

  always_comb begin
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    if (cfg_acc) begin
      unique case (cfg_bus.index)
        ofd_pkg::CFG_GRID_WIDTH:  cfg_width_nxt  = cfg_bus.data;
        ofd_pkg::CFG_GRID_HEIGHT: cfg_height_nxt = cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign eff_w = clamp_dim(cfg_width_r, ofd_pkg::MAX_WIDTH);
  assign eff_h = clamp_dim(cfg_height_r, ofd_pkg::MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= ofd_pkg::CFG_W'(1024);
      cfg_height_r <= ofd_pkg::CFG_W'(1024);
      cfg_pend_r   <= 1'b0;
      total_r      <= (ofd_pkg::CNT_W + 1)'(1024 * 1024);
    end else begin
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      cfg_pend_r   <= cfg_acc;
      total_r      <= (ofd_pkg::CNT_W + 1)'(eff_w * eff_h);
    end
  end

  // The reported position is kept as row and column; a new width needs them re-derived
  // from the running count.
  ofd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_pend_r),
    .dividend (out_cnt_r),
    .divisor  (eff_w),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // ---------------------------------------------------------------------------
  // Accept stage: counters and boundary flags
  // ---------------------------------------------------------------------------
  assign p1_adv = p1_valid_r && (!p1_r.emit || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !div_stat.busy && !cfg_pend_r && (!p1_valid_r || p1_adv);
  assign in_acc = in_bus.valid && in_bus.ready;

  always_comb begin
    cls_in    = classify(in_bus.cell_value, in_bus.flush);
    emit      = (in_row_r >= ofd_pkg::IN_ROW_W'(2)) ||
                ((in_row_r == ofd_pkg::IN_ROW_W'(1)) && (in_col_r != '0));
    last      = ((ofd_pkg::CNT_W + 1)'(out_cnt_r) + 1'b1) >= total_r;
    col_wrap  = (ofd_pkg::DIV_W'(in_col_r) + 1'b1) >= ofd_pkg::DIV_W'(eff_w);
    ocol_wrap = (ofd_pkg::DIV_W'(ocol_r) + 1'b1) >= ofd_pkg::DIV_W'(eff_w);
    bot_ok    = ((ofd_pkg::CNT_W + 1)'(orow_r) + 1'b1) < (ofd_pkg::CNT_W + 1)'(eff_h);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_cnt_nxt = out_cnt_r;
    orow_nxt    = orow_r;
    ocol_nxt    = ocol_r;
    if (in_acc) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        if (in_row_r != '1) begin
          in_row_nxt = in_row_r + 1'b1;
        end
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_cnt_nxt = '0;
          orow_nxt    = '0;
          ocol_nxt    = '0;
        end else begin
          out_cnt_nxt = out_cnt_r + 1'b1;
          if (ocol_wrap) begin
            ocol_nxt = '0;
            orow_nxt = orow_r + 1'b1;
          end else begin
            ocol_nxt = ocol_r + 1'b1;
          end
        end
      end
    end else if (div_stat.done) begin
      orow_nxt = div_quo;
      ocol_nxt = div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_cnt_r <= '0;
      orow_r    <= '0;
      ocol_r    <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_cnt_r <= out_cnt_nxt;
      orow_r    <= orow_nxt;
      ocol_r    <= ocol_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers. The read for an item is issued on its accepting edge; when the item
  // ahead writes the same entry on that edge, its data is forwarded instead.
  // ---------------------------------------------------------------------------
  assign up_eff  = p1_r.fwd ? p1_r.fwd_up  : rd_up_r;
  assign mid_eff = p1_r.fwd ? p1_r.fwd_mid : rd_mid_r;

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      upper_mem[p1_r.idx]  <= mid_eff;
      middle_mem[p1_r.idx] <= p1_r.cls;
    end
    if (in_acc) begin
      rd_up_r  <= upper_mem[in_col_r];
      rd_mid_r <= middle_mem[in_col_r];
    end
  end

  always_comb begin
    p1_nxt          = p1_r;
    p1_nxt.cls      = cls_in;
    p1_nxt.idx      = in_col_r;
    p1_nxt.emit     = emit;
    p1_nxt.last     = emit && last;
    p1_nxt.first    = (in_col_r == '0);
    p1_nxt.top_ok   = (orow_r != '0);
    p1_nxt.bot_ok   = bot_ok;
    p1_nxt.left_ok  = (ocol_r != '0);
    p1_nxt.right_ok = !ocol_wrap;
    p1_nxt.row      = orow_r[ofd_pkg::POS_W-1:0];
    p1_nxt.col      = ofd_pkg::POS_W'(ocol_r);
    p1_nxt.fwd      = p1_valid_r && p1_adv && (p1_r.idx == in_col_r);
    p1_nxt.fwd_up   = mid_eff;
    p1_nxt.fwd_mid  = p1_r.cls;
    p1_valid_nxt    = in_acc ? 1'b1 : (p1_adv ? 1'b0 : p1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_r <= p1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Window cells: the newest column enters at the top of the chain each beat.
  // ---------------------------------------------------------------------------
  assign new_col.top = up_eff;
  assign new_col.mid = mid_eff;
  assign new_col.bot = p1_r.cls;
  assign chain[ofd_pkg::NUM_CELLS] = new_col;

  assign cell_ctl.shift = p1_adv;
  assign cell_ctl.clear = p1_adv && p1_r.last;

  for (genvar i = 0; i < ofd_pkg::NUM_CELLS; i++) begin : g_cell
    ofd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .col_in  (chain[i+1]),
      .col_out (chain[i])
    );
  end

  // At the first column of a row the reported cell is the last one of the row above,
  // and the incoming column is not its neighbour.
  always_comb begin
    flag = (chain[1].mid == ofd_pkg::CLS_FREE) &&
           ((p1_r.left_ok && has_unknown(chain[0], p1_r.top_ok, p1_r.bot_ok, 1'b1)) ||
            has_unknown(chain[1], p1_r.top_ok, p1_r.bot_ok, 1'b0) ||
            (!p1_r.first && p1_r.right_ok &&
             has_unknown(new_col, p1_r.top_ok, p1_r.bot_ok, 1'b1)));
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p1_adv && p1_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv && p1_r.emit) begin
      out_frontier_r <= flag;
      out_row_r      <= p1_r.row;
      out_col_r      <= p1_r.col;
      out_last_r     <= p1_r.last;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.is_frontier   = out_frontier_r;
  assign out_bus.cell_row      = out_row_r;
  assign out_bus.cell_col      = out_col_r;
  assign out_bus.last_of_frame = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ocol_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!div_stat.busy && !cfg_pend_r) |->
      (ofd_pkg::DIV_W'(ocol_r) < ofd_pkg::DIV_W'(eff_w)))
    else $error("reported column outside the grid width");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_adv && p1_r.last) |=> ((chain[0] == '0) && (chain[1] == '0)))
    else $error("window not cleared after the final cell of a frame");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && last) |=>
      ((out_cnt_r == '0) && (in_col_r == '0) && (in_row_r == '0) && (orow_r == '0)))
    else $error("position counters not restarted at the end of a frame");

endmodule
